[sv/rtx_pkg.sv]
// Shared constants, function codes and the execute result type for the R-type execute unit.
`default_nettype none
package rtx_pkg;

  // Register file geometry
  localparam int unsigned RF_DEPTH = 32;
  localparam int unsigned RF_IDX_W = 5;
  localparam int unsigned DATA_W   = 32;

  // Request actions
  localparam logic ACT_EXEC  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Function codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_NAND  = 6'h28;
  localparam logic [5:0] FN_SLT   = 6'h2a;

  // Everything one request produces
  typedef struct packed {
    logic              do_write;
    logic [DATA_W-1:0] res;
    logic              jump;
    logic [DATA_W-1:0] target;
    logic              zero_err;
    logic              ovf;
    logic              hl_err;
    logic [DATA_W-1:0] hi_nxt;
    logic [DATA_W-1:0] lo_nxt;
    logic              unread_nxt;
  } exe_res_t;

endpackage
`default_nettype wire

[sv/rtx_alu.sv]
// Combinational execute logic: operation decode, ALU, shifter, multiplier and error flags.
`default_nettype none
module rtx_alu (
  input  wire logic                         action,
  input  wire logic [rtx_pkg::RF_IDX_W-1:0] rt_idx,
  input  wire logic [rtx_pkg::RF_IDX_W-1:0] rd_idx,
  input  wire logic [4:0]                   shamt,
  input  wire logic [5:0]                   funct,
  input  wire logic [rtx_pkg::DATA_W-1:0]   wr_value,
  input  wire logic [rtx_pkg::DATA_W-1:0]   op_a,
  input  wire logic [rtx_pkg::DATA_W-1:0]   op_b,
  input  wire logic [rtx_pkg::DATA_W-1:0]   hi_cur,
  input  wire logic [rtx_pkg::DATA_W-1:0]   lo_cur,
  input  wire logic                         unread_cur,
  output rtx_pkg::exe_res_t                 res_o
);

  logic                          wr_raw;
  logic [rtx_pkg::DATA_W-1:0]    sum;
  logic [rtx_pkg::DATA_W-1:0]    diff;
  logic                          mul_sgn;
  logic signed [rtx_pkg::DATA_W:0]     mul_a;
  logic signed [rtx_pkg::DATA_W:0]     mul_b;
  logic signed [2*rtx_pkg::DATA_W+1:0] prod;

  // Shared adder, subtractor and multiplier
  assign sum     = op_a + op_b;
  assign diff    = op_a - op_b;
  assign mul_sgn = (funct == rtx_pkg::FN_MULT);
  assign mul_a   = $signed({mul_sgn & op_a[rtx_pkg::DATA_W-1], op_a});
  assign mul_b   = $signed({mul_sgn & op_b[rtx_pkg::DATA_W-1], op_b});
  assign prod    = mul_a * mul_b;

  // Decode the operation and select the result
  always_comb begin
    wr_raw            = 1'b0;
    res_o             = '0;
    res_o.hi_nxt      = hi_cur;
    res_o.lo_nxt      = lo_cur;
    res_o.unread_nxt  = unread_cur;
    if (action == rtx_pkg::ACT_WRITE) begin
      wr_raw    = 1'b1;
      res_o.res = wr_value;
    end else begin
      case (funct)
        rtx_pkg::FN_ADD: begin
          wr_raw    = 1'b1;
          res_o.res = sum;
          res_o.ovf = ~(op_a[31] ^ op_b[31]) & (op_a[31] ^ sum[31]);
        end
        rtx_pkg::FN_ADDU: begin
          wr_raw    = 1'b1;
          res_o.res = sum;
        end
        rtx_pkg::FN_SUB: begin
          wr_raw    = 1'b1;
          res_o.res = diff;
          res_o.ovf = (op_a[31] ^ op_b[31]) & (op_a[31] ^ diff[31]);
        end
        rtx_pkg::FN_AND: begin
          wr_raw    = 1'b1;
          res_o.res = op_a & op_b;
        end
        rtx_pkg::FN_OR: begin
          wr_raw    = 1'b1;
          res_o.res = op_a | op_b;
        end
        rtx_pkg::FN_XOR: begin
          wr_raw    = 1'b1;
          res_o.res = op_a ^ op_b;
        end
        rtx_pkg::FN_NOR: begin
          wr_raw    = 1'b1;
          res_o.res = ~(op_a | op_b);
        end
        rtx_pkg::FN_NAND: begin
          wr_raw    = 1'b1;
          res_o.res = ~(op_a & op_b);
        end
        rtx_pkg::FN_SLT: begin
          wr_raw    = 1'b1;
          res_o.res = {{(rtx_pkg::DATA_W-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
        end
        rtx_pkg::FN_SLL: begin
          // all-zero encoding is a nop
          if (rt_idx != '0 || rd_idx != '0 || shamt != '0) begin
            wr_raw    = 1'b1;
            res_o.res = op_b << shamt;
          end
        end
        rtx_pkg::FN_SRL: begin
          wr_raw    = 1'b1;
          res_o.res = op_b >> shamt;
        end
        rtx_pkg::FN_SRA: begin
          wr_raw    = 1'b1;
          res_o.res = $unsigned($signed(op_b) >>> shamt);
        end
        rtx_pkg::FN_JR: begin
          res_o.jump   = 1'b1;
          res_o.target = op_a;
        end
        rtx_pkg::FN_MULT, rtx_pkg::FN_MULTU: begin
          res_o.hi_nxt     = prod[2*rtx_pkg::DATA_W-1:rtx_pkg::DATA_W];
          res_o.lo_nxt     = prod[rtx_pkg::DATA_W-1:0];
          res_o.hl_err     = unread_cur;
          res_o.unread_nxt = 1'b1;
        end
        rtx_pkg::FN_MFHI: begin
          wr_raw           = 1'b1;
          res_o.res        = hi_cur;
          res_o.unread_nxt = 1'b0;
        end
        rtx_pkg::FN_MFLO: begin
          wr_raw           = 1'b1;
          res_o.res        = lo_cur;
          res_o.unread_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      res_o.zero_err = wr_raw & (rd_idx == '0);
    end
    // drop writes to register zero
    res_o.do_write = wr_raw & (rd_idx != '0);
    if (!res_o.do_write) begin
      res_o.res = '0;
    end
  end

endmodule
`default_nettype wire

[sv/rtype_execute_unit.sv]
// Top level of the R-type execute unit: register file, HI/LO state and the two-stage pipeline.
//
// Usage: each input request carries one instruction (action 0) or a direct register
// write (action 1). Each accepted request yields exactly one result on the out_ channel,
// in order. A request is taken at a clock edge with in_valid high and in_stall low; a
// result is taken at an edge with out_valid high and out_stall low.
// The register file is read at the accept edge, the instruction executes in one pass of
// logic from the input register, and the outcome lands in the result register.
// Throughput: one request per cycle while out_stall is low; a result that depends on
// the previous request's destination register is taken from a bypass of the register
// file write port.
// Reset (synchronous, rst_n low): the pipeline empties, all registers, HI, LO and the
// unread flag read as zero.
// Stall: while out_stall holds a waiting result, the request in the execute stage holds
// and in_stall rises; state changes only when a request moves into the result register.
`default_nettype none
module rtype_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [4:0]  in_src_a_index,
  input  wire logic [4:0]  in_src_b_index,
  input  wire logic [4:0]  in_dest_index,
  input  wire logic [4:0]  in_shift_amount,
  input  wire logic [5:0]  in_funct_code,
  input  wire logic [31:0] in_write_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_reg_written,
  output logic [4:0]       out_written_index,
  output logic [31:0]      out_written_value,
  output logic             out_jump_taken,
  output logic [31:0]      out_jump_target,
  output logic [31:0]      out_hi_value,
  output logic [31:0]      out_lo_value,
  output logic             out_zero_write_error,
  output logic             out_overflow_error,
  output logic             out_hilo_overwrite_error
);

  localparam int unsigned DW = rtx_pkg::DATA_W;
  localparam int unsigned IW = rtx_pkg::RF_IDX_W;

  // Register file storage and per-entry written flags
  logic [DW-1:0]               rf_mem [rtx_pkg::RF_DEPTH];
  logic [rtx_pkg::RF_DEPTH-1:0] rf_vld_r;

  // Execute stage
  logic          s1_vld_r;
  logic          s1_action_r;
  logic [IW-1:0] s1_rt_r;
  logic [IW-1:0] s1_rd_r;
  logic [4:0]    s1_sh_r;
  logic [5:0]    s1_fn_r;
  logic [DW-1:0] s1_wv_r;
  logic [DW-1:0] rd_a_r;
  logic [DW-1:0] rd_b_r;
  logic          a_vld_r;
  logic          b_vld_r;
  logic          a_fwd_r;
  logic          b_fwd_r;
  logic [DW-1:0] fwd_val_r;

  // Architectural HI/LO state
  logic [DW-1:0] hi_r;
  logic [DW-1:0] lo_r;
  logic          unread_r;

  logic          out_vld_r;
  logic          in_acc;
  logic          s1_adv;
  logic          wr_en;
  logic [DW-1:0] op_a;
  logic [DW-1:0] op_b;
  rtx_pkg::exe_res_t exe;

  // Handshake
  assign s1_adv   = s1_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = s1_vld_r & ~s1_adv;
  assign in_acc   = in_valid & ~in_stall;
  assign wr_en    = s1_adv & exe.do_write;

  // Operand select: bypass, stored value, or reset value
  always_comb begin
    if (a_fwd_r) begin
      op_a = fwd_val_r;
    end else if (a_vld_r) begin
      op_a = rd_a_r;
    end else begin
      op_a = '0;
    end
    if (b_fwd_r) begin
      op_b = fwd_val_r;
    end else if (b_vld_r) begin
      op_b = rd_b_r;
    end else begin
      op_b = '0;
    end
  end

  rtx_alu u_alu (
    .action     (s1_action_r),
    .rt_idx     (s1_rt_r),
    .rd_idx     (s1_rd_r),
    .shamt      (s1_sh_r),
    .funct      (s1_fn_r),
    .wr_value   (s1_wv_r),
    .op_a       (op_a),
    .op_b       (op_b),
    .hi_cur     (hi_r),
    .lo_cur     (lo_r),
    .unread_cur (unread_r),
    .res_o      (exe)
  );

  // Register file write and read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[s1_rd_r] <= exe.res;
    end
    if (in_acc) begin
      rd_a_r <= rf_mem[in_src_a_index];
      rd_b_r <= rf_mem[in_src_b_index];
    end
  end

  // Capture the request and the bypass for a same-edge write
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_rt_r     <= in_src_b_index;
      s1_rd_r     <= in_dest_index;
      s1_sh_r     <= in_shift_amount;
      s1_fn_r     <= in_funct_code;
      s1_wv_r     <= in_write_value;
      a_vld_r     <= rf_vld_r[in_src_a_index];
      b_vld_r     <= rf_vld_r[in_src_b_index];
      a_fwd_r     <= wr_en & (s1_rd_r == in_src_a_index);
      b_fwd_r     <= wr_en & (s1_rd_r == in_src_b_index);
      fwd_val_r   <= exe.res;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      rf_vld_r  <= '0;
      hi_r      <= '0;
      lo_r      <= '0;
      unread_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (wr_en) begin
        rf_vld_r[s1_rd_r] <= 1'b1;
      end
      if (s1_adv) begin
        hi_r     <= exe.hi_nxt;
        lo_r     <= exe.lo_nxt;
        unread_r <= exe.unread_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_reg_written          <= exe.do_write;
      out_written_index        <= exe.do_write ? s1_rd_r : '0;
      out_written_value        <= exe.res;
      out_jump_taken           <= exe.jump;
      out_jump_target          <= exe.target;
      out_hi_value             <= exe.hi_nxt;
      out_lo_value             <= exe.lo_nxt;
      out_zero_write_error     <= exe.zero_err;
      out_overflow_error       <= exe.ovf;
      out_hilo_overwrite_error <= exe.hl_err;
    end
  end

  assign out_valid = out_vld_r;

endmodule
`default_nettype wire

[tb/rtype_result_checker.sv]
// Result checker for the R-type execute unit: mirrors its state, predicts each result and compares.
`timescale 1ns / 100ps
module rtype_result_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        in_action,
  input  wire logic [4:0]  in_src_a_index,
  input  wire logic [4:0]  in_src_b_index,
  input  wire logic [4:0]  in_dest_index,
  input  wire logic [4:0]  in_shift_amount,
  input  wire logic [5:0]  in_funct_code,
  input  wire logic [31:0] in_write_value,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_reg_written,
  input  wire logic [4:0]  out_written_index,
  input  wire logic [31:0] out_written_value,
  input  wire logic        out_jump_taken,
  input  wire logic [31:0] out_jump_target,
  input  wire logic [31:0] out_hi_value,
  input  wire logic [31:0] out_lo_value,
  input  wire logic        out_zero_write_error,
  input  wire logic        out_overflow_error,
  input  wire logic        out_hilo_overwrite_error,
  output int               fail_count,
  output int               outstanding
);

  typedef struct packed {
    logic                       reg_written;
    logic [4:0]                 written_index;
    logic [rtx_pkg::DATA_W-1:0] written_value;
    logic                       jump_taken;
    logic [rtx_pkg::DATA_W-1:0] jump_target;
    logic [rtx_pkg::DATA_W-1:0] hi_value;
    logic [rtx_pkg::DATA_W-1:0] lo_value;
    logic                       zero_write_error;
    logic                       overflow_error;
    logic                       hilo_overwrite_error;
  } retire_t;

  // Mirror of the architectural state
  logic [rtx_pkg::DATA_W-1:0] gpr [rtx_pkg::RF_DEPTH];
  logic [rtx_pkg::DATA_W-1:0] hi_reg;
  logic [rtx_pkg::DATA_W-1:0] lo_reg;
  logic                       hilo_fresh;

  retire_t retire_queue[$];
  int      errors = 0;

  // Execute one request against the mirror and return what the unit should retire
  function automatic retire_t compute_retire(logic act, logic [4:0] rs, logic [4:0] rt,
                                             logic [4:0] rd, logic [4:0] sh, logic [5:0] fn,
                                             logic [rtx_pkg::DATA_W-1:0] wv);
    logic [rtx_pkg::DATA_W-1:0] a;
    logic [rtx_pkg::DATA_W-1:0] b;
    logic [rtx_pkg::DATA_W-1:0] res;
    logic                       wr;
    logic [63:0]                prod;
    retire_t                    r;
    a   = gpr[rs];
    b   = gpr[rt];
    wr  = 1'b0;
    res = '0;
    r   = '0;
    if (act == rtx_pkg::ACT_WRITE) begin
      wr  = 1'b1;
      res = wv;
    end else begin
      case (fn)
        rtx_pkg::FN_ADD: begin
          res = a + b;
          r.overflow_error = ~(a[31] ^ b[31]) & (a[31] ^ res[31]);
          wr = 1'b1;
        end
        rtx_pkg::FN_ADDU: begin
          res = a + b;
          wr  = 1'b1;
        end
        rtx_pkg::FN_SUB: begin
          res = a - b;
          r.overflow_error = (a[31] ^ b[31]) & (a[31] ^ res[31]);
          wr = 1'b1;
        end
        rtx_pkg::FN_AND: begin res = a & b;      wr = 1'b1; end
        rtx_pkg::FN_OR: begin res = a | b;       wr = 1'b1; end
        rtx_pkg::FN_XOR: begin res = a ^ b;      wr = 1'b1; end
        rtx_pkg::FN_NOR: begin res = ~(a | b);   wr = 1'b1; end
        rtx_pkg::FN_NAND: begin res = ~(a & b);  wr = 1'b1; end
        rtx_pkg::FN_SLT: begin
          res = {31'b0, ($signed(a) < $signed(b))};
          wr  = 1'b1;
        end
        rtx_pkg::FN_SLL: begin
          // all-zero rt, rd and shift is a nop
          if (rt != 0 || rd != 0 || sh != 0) begin
            res = b << sh;
            wr  = 1'b1;
          end
        end
        rtx_pkg::FN_SRL: begin res = b >> sh; wr = 1'b1; end
        rtx_pkg::FN_SRA: begin
          res = $signed(b) >>> sh;
          wr  = 1'b1;
        end
        rtx_pkg::FN_JR: begin
          r.jump_taken  = 1'b1;
          r.jump_target = a;
        end
        rtx_pkg::FN_MULT, rtx_pkg::FN_MULTU: begin
          if (fn == rtx_pkg::FN_MULT) prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
          else prod = {32'b0, a} * {32'b0, b};
          hi_reg = prod[63:32];
          lo_reg = prod[31:0];
          r.hilo_overwrite_error = hilo_fresh;
          hilo_fresh = 1'b1;
        end
        rtx_pkg::FN_MFHI: begin
          res = hi_reg;
          hilo_fresh = 1'b0;
          wr = 1'b1;
        end
        rtx_pkg::FN_MFLO: begin
          res = lo_reg;
          hilo_fresh = 1'b0;
          wr = 1'b1;
        end
        default: ;
      endcase
      r.zero_write_error = wr && (rd == 0);
    end
    // register zero never changes; a direct write to it is silently dropped
    if (rd == 0) wr = 1'b0;
    if (wr) gpr[rd] = res;
    r.reg_written   = wr;
    r.written_index = wr ? rd : 5'd0;
    r.written_value = wr ? res : '0;
    r.hi_value      = hi_reg;
    r.lo_value      = lo_reg;
    return r;
  endfunction

  task automatic check_field(string name, logic [rtx_pkg::DATA_W-1:0] want,
                             logic [rtx_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      errors++;
    end
  endtask

  // Retire results against the oldest prediction, then predict the new request
  always @(posedge clk) begin
    retire_t want;
    if (!rst_n) begin
      for (int i = 0; i < rtx_pkg::RF_DEPTH; i++) gpr[i] = '0;
      hi_reg     = '0;
      lo_reg     = '0;
      hilo_fresh = 1'b0;
      retire_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (retire_queue.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          want = retire_queue.pop_front();
          check_field("reg_written", want.reg_written, out_reg_written);
          check_field("written_index", want.written_index, out_written_index);
          check_field("written_value", want.written_value, out_written_value);
          check_field("jump_taken", want.jump_taken, out_jump_taken);
          check_field("jump_target", want.jump_target, out_jump_target);
          check_field("hi_value", want.hi_value, out_hi_value);
          check_field("lo_value", want.lo_value, out_lo_value);
          check_field("zero_write_error", want.zero_write_error, out_zero_write_error);
          check_field("overflow_error", want.overflow_error, out_overflow_error);
          check_field("hilo_overwrite_error", want.hilo_overwrite_error,
                      out_hilo_overwrite_error);
        end
      end
      if (in_valid && !in_stall) begin
        retire_queue.push_back(compute_retire(in_action, in_src_a_index, in_src_b_index,
                                              in_dest_index, in_shift_amount, in_funct_code,
                                              in_write_value));
      end
    end
    fail_count  <= errors;
    outstanding <= retire_queue.size();
  end

endmodule

[tb/tb_top.sv]
// Testbench top for the R-type execute unit: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;

  localparam int         RANDOM_REQUESTS  = 1250;
  localparam int         LONG_HOLD_CYCLES = 64;
  localparam logic [5:0] FN_UNKNOWN       = 6'h3f;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_action       = rtx_pkg::ACT_EXEC;
  logic [4:0]  in_src_a_index  = '0;
  logic [4:0]  in_src_b_index  = '0;
  logic [4:0]  in_dest_index   = '0;
  logic [4:0]  in_shift_amount = '0;
  logic [5:0]  in_funct_code   = '0;
  logic [31:0] in_write_value  = '0;
  logic        out_stall       = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_reg_written;
  logic [4:0]  out_written_index;
  logic [31:0] out_written_value;
  logic        out_jump_taken;
  logic [31:0] out_jump_target;
  logic [31:0] out_hi_value;
  logic [31:0] out_lo_value;
  logic        out_zero_write_error;
  logic        out_overflow_error;
  logic        out_hilo_overwrite_error;
  int          fail_count;
  int          outstanding;
  int          accepted_count = 0;

  rtype_execute_unit u_dut (.*);

  rtype_result_checker u_checker (.*);

  always #5 clk = ~clk;

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one request and hold it until the unit takes it
  task automatic send_request(logic act, logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                              logic [4:0] sh, logic [5:0] fn, logic [31:0] wv);
    in_valid        <= 1'b1;
    in_action       <= act;
    in_src_a_index  <= rs;
    in_src_b_index  <= rt;
    in_dest_index   <= rd;
    in_shift_amount <= sh;
    in_funct_code   <= fn;
    in_write_value  <= wv;
    do @(posedge clk); while (in_stall);
    accepted_count++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [5:0] pick_funct();
    case ($urandom_range(0, 16))
      0:       return rtx_pkg::FN_SLL;
      1:       return rtx_pkg::FN_SRL;
      2:       return rtx_pkg::FN_SRA;
      3:       return rtx_pkg::FN_JR;
      4:       return rtx_pkg::FN_MFHI;
      5:       return rtx_pkg::FN_MFLO;
      6:       return rtx_pkg::FN_MULT;
      7:       return rtx_pkg::FN_MULTU;
      8:       return rtx_pkg::FN_ADD;
      9:       return rtx_pkg::FN_ADDU;
      10:      return rtx_pkg::FN_SUB;
      11:      return rtx_pkg::FN_AND;
      12:      return rtx_pkg::FN_OR;
      13:      return rtx_pkg::FN_XOR;
      14:      return rtx_pkg::FN_NOR;
      15:      return rtx_pkg::FN_NAND;
      default: return rtx_pkg::FN_SLT;
    endcase
  endfunction

  // Favor corner values so that overflow and sign cases show up often
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      4:       return 32'hffff_ffff;
      5:       return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  // Receiver: stall on a changing duty cycle, with one long hold-off once traffic is up
  initial begin : rx_pattern
    int  mode_left;
    int  stall_pct;
    bit  held;
    mode_left = 0;
    stall_pct = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && accepted_count >= 300) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Sender: directed corners, then bursts of random requests
  initial begin : stimulus
    int  burst;
    int  gap;
    int  sent;
    bit  paused;
    logic        act;
    logic [5:0]  fn;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // preload extremes, including an ignored write to register zero
    send_request(rtx_pkg::ACT_WRITE, 0, 0, 1, 0, rtx_pkg::FN_SLL, 32'h7fff_ffff);
    send_request(rtx_pkg::ACT_WRITE, 0, 0, 2, 0, rtx_pkg::FN_SLL, 32'h8000_0000);
    send_request(rtx_pkg::ACT_WRITE, 0, 0, 3, 0, rtx_pkg::FN_SLL, 32'hffff_ffff);
    send_request(rtx_pkg::ACT_WRITE, 0, 0, 4, 0, rtx_pkg::FN_SLL, 32'h0000_0001);
    send_request(rtx_pkg::ACT_WRITE, 0, 0, 0, 0, rtx_pkg::FN_SLL, 32'hdead_beef);
    // arithmetic with and without signed overflow
    send_request(rtx_pkg::ACT_EXEC, 1, 4, 5, 0, rtx_pkg::FN_ADD, '0);
    send_request(rtx_pkg::ACT_EXEC, 2, 4, 6, 0, rtx_pkg::FN_SUB, '0);
    send_request(rtx_pkg::ACT_EXEC, 3, 4, 7, 0, rtx_pkg::FN_ADDU, '0);
    // logic ops and signed compare
    send_request(rtx_pkg::ACT_EXEC, 1, 2, 8, 0, rtx_pkg::FN_AND, '0);
    send_request(rtx_pkg::ACT_EXEC, 1, 2, 8, 0, rtx_pkg::FN_OR, '0);
    send_request(rtx_pkg::ACT_EXEC, 3, 1, 8, 0, rtx_pkg::FN_XOR, '0);
    send_request(rtx_pkg::ACT_EXEC, 1, 4, 8, 0, rtx_pkg::FN_NOR, '0);
    send_request(rtx_pkg::ACT_EXEC, 3, 3, 8, 0, rtx_pkg::FN_NAND, '0);
    send_request(rtx_pkg::ACT_EXEC, 2, 1, 9, 0, rtx_pkg::FN_SLT, '0);
    // shifts at full distance, then a nop with a nonzero rs
    send_request(rtx_pkg::ACT_EXEC, 0, 3, 10, 31, rtx_pkg::FN_SLL, '0);
    send_request(rtx_pkg::ACT_EXEC, 0, 2, 11, 31, rtx_pkg::FN_SRL, '0);
    send_request(rtx_pkg::ACT_EXEC, 0, 2, 12, 31, rtx_pkg::FN_SRA, '0);
    send_request(rtx_pkg::ACT_EXEC, 7, 0, 0, 0, rtx_pkg::FN_SLL, '0);
    send_request(rtx_pkg::ACT_EXEC, 3, 0, 0, 0, rtx_pkg::FN_JR, '0);
    // back-to-back products flag an unread overwrite
    send_request(rtx_pkg::ACT_EXEC, 2, 3, 0, 0, rtx_pkg::FN_MULT, '0);
    send_request(rtx_pkg::ACT_EXEC, 3, 3, 0, 0, rtx_pkg::FN_MULTU, '0);
    send_request(rtx_pkg::ACT_EXEC, 0, 0, 31, 0, rtx_pkg::FN_MFHI, '0);
    // destination zero still reports its errors
    send_request(rtx_pkg::ACT_EXEC, 0, 0, 0, 0, rtx_pkg::FN_MFLO, '0);
    send_request(rtx_pkg::ACT_EXEC, 1, 4, 0, 0, rtx_pkg::FN_ADD, '0);
    send_request(rtx_pkg::ACT_EXEC, 1, 2, 14, 5, FN_UNKNOWN, '0);
    wait_drained();

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst; i++) begin
        act = ($urandom_range(0, 99) < 15) ? rtx_pkg::ACT_WRITE : rtx_pkg::ACT_EXEC;
        fn  = ($urandom_range(0, 99) < 85) ? pick_funct() : 6'($urandom_range(0, 63));
        send_request(act, 5'($urandom()), 5'($urandom()), 5'($urandom()),
                     5'($urandom()), fn, pick_value());
        sent++;
      end
      // pause once until the unit is empty
      if (!paused && sent >= 700) begin
        paused = 1'b1;
        wait_drained();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/rtx_pkg.sv
sv/rtx_alu.sv
sv/rtype_execute_unit.sv
tb/rtype_result_checker.sv
tb/tb_top.sv
